@@ rtl/sbp_pkg.sv @@
// shared types, codes and constants of the symmetric border padding block
package sbp_pkg;

    // field widths fixed by the interface
    localparam int PIX_W   = 32;
    localparam int COORD_W = 10;
    localparam int DIM_W   = 10;
    localparam int BORD_W  = 7;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // coordinate arithmetic width, covers 2*dim+border and an 8191 maximum
    localparam int CALC_W = 13;

    // default sizes of the frame store
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_MAX_BORDER = 64;

    // queue depths between and after the two halves
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_SIZE  = 2'd2;

    // reset values of the registers
    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 10'd512;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 10'd512;
    localparam logic [BORD_W-1:0] RST_BORDER_SIZE  = 7'd0;

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BORDER  = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [BORD_W-1:0] border;
    } t_cfg;

    // classified request, source coordinates already mirrored
    typedef struct packed {
        logic               is_write;
        logic [STAT_W-1:0]  status;
        logic [COORD_W-1:0] src_row;
        logic [COORD_W-1:0] src_col;
        logic [PIX_W-1:0]   pixel;
    } t_cmd;

    typedef struct packed {
        logic                 rd_pending;
        logic [OUT_CNT_W-1:0] out_count;
    } t_back_stat;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

@@ rtl/sbp_front.sv @@
// front half: takes requests, clamps the sizes, mirrors coordinates, classifies
module sbp_front #(
    parameter int MAX_WIDTH  = sbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sbp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_BORDER = sbp_pkg::DEF_MAX_BORDER
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sbp_pkg::t_cfg                i_cfg,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic                         i_opcode,
    input  logic [sbp_pkg::COORD_W-1:0]  i_row,
    input  logic [sbp_pkg::COORD_W-1:0]  i_column,
    input  logic [sbp_pkg::PIX_W-1:0]    i_pixel_in,
    output logic                         o_cmd_vld,
    output sbp_pkg::t_cmd                o_cmd,
    input  logic                         i_q_full
);
    import sbp_pkg::*;

    logic [CALC_W-1:0] w_eff, h_eff, b_eff;
    logic [CALC_W-1:0] row_p, col_p;
    logic [CALC_W-1:0] row_src, col_src;
    logic              outside, too_wide, write_ok, keep;
    logic              accept, hand_off;
    logic              r_vld, n_vld;
    t_cmd              r_cmd, n_cmd;

    // single reflection of p onto [0, n)
    function automatic logic [CALC_W-1:0] mirror(
        input logic [CALC_W-1:0] p,
        input logic [CALC_W-1:0] n,
        input logic [CALC_W-1:0] b
    );
        logic [CALC_W-1:0] res;
        if (p < b) begin
            res = b - p - CALC_W'(1);
        end else if (p < n + b) begin
            res = p - b;
        end else begin
            res = (n << 1) + b - p - CALC_W'(1);
        end
        return res;
    endfunction

    always_comb begin
        w_eff = (CALC_W'(i_cfg.width) > CALC_W'(MAX_WIDTH)) ?
                CALC_W'(MAX_WIDTH) : CALC_W'(i_cfg.width);
        h_eff = (CALC_W'(i_cfg.height) > CALC_W'(MAX_HEIGHT)) ?
                CALC_W'(MAX_HEIGHT) : CALC_W'(i_cfg.height);
        b_eff = (CALC_W'(i_cfg.border) > CALC_W'(MAX_BORDER)) ?
                CALC_W'(MAX_BORDER) : CALC_W'(i_cfg.border);
        row_p = CALC_W'(i_row);
        col_p = CALC_W'(i_column);

        outside  = (row_p >= h_eff + (b_eff << 1)) || (col_p >= w_eff + (b_eff << 1));
        too_wide = (b_eff > w_eff) || (b_eff > h_eff);
        write_ok = (row_p < h_eff) && (col_p < w_eff);
        keep     = (i_opcode == OP_READ) || write_ok;

        row_src = mirror(row_p, h_eff, b_eff);
        col_src = mirror(col_p, w_eff, b_eff);

        n_cmd.is_write = (i_opcode == OP_WRITE);
        n_cmd.pixel    = i_pixel_in;
        if (i_opcode == OP_WRITE) begin
            n_cmd.status  = ST_OK;
            n_cmd.src_row = i_row;
            n_cmd.src_col = i_column;
        end else begin
            n_cmd.status  = outside ? ST_OUTSIDE : (too_wide ? ST_BORDER : ST_OK);
            n_cmd.src_row = row_src[COORD_W-1:0];
            n_cmd.src_col = col_src[COORD_W-1:0];
        end
    end

    assign o_full   = r_vld && i_q_full;
    assign accept   = i_push && !o_full;
    assign hand_off = r_vld && !i_q_full;

    // writes outside the image are dropped here
    always_comb begin
        if (accept) begin
            n_vld = keep;
        end else if (hand_off) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_vld = r_vld;
    assign o_cmd     = r_cmd;

endmodule

@@ rtl/sbp_cmd_queue.sv @@
// short command queue between the front and back halves
module sbp_cmd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sbp_pkg::t_cmd        i_cmd,
    input  logic                 i_pop,
    output sbp_pkg::t_cmd        o_cmd,
    output sbp_pkg::t_queue_stat o_stat
);
    import sbp_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    t_cmd             r_entry [CMD_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_count == CNT_W'(CMD_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_entry[r_rptr];

    always_comb begin
        n_wptr  = do_push ? r_wptr + PTR_W'(1) : r_wptr;
        n_rptr  = do_pop ? r_rptr + PTR_W'(1) : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/sbp_back.sv @@
// back half: frame store access and result queue
module sbp_back #(
    parameter int MAX_WIDTH  = sbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sbp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbp_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_empty,
    output logic                        o_cmd_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [sbp_pkg::PIX_W-1:0]   o_pixel_out,
    output logic [sbp_pkg::STAT_W-1:0]  o_status,
    output sbp_pkg::t_back_stat         o_stat
);
    import sbp_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PIX_W-1:0]     r_mem [DEPTH];
    logic [AW-1:0]        addr;
    logic                 room, issue;
    logic                 r_rd_vld;
    logic [STAT_W-1:0]    r_rd_status;
    logic [PIX_W-1:0]     r_rd_data;

    logic [PIX_W-1:0]     r_out_pix  [OUT_DEPTH];
    logic [STAT_W-1:0]    r_out_stat [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wptr, r_rptr;
    logic [OUT_CNT_W-1:0] r_count, n_count;
    logic                 out_push, out_pop;

    // row-major address into the store
    assign addr = AW'(i_cmd.src_row) * AW'(MAX_WIDTH) + AW'(i_cmd.src_col);

    // a read goes out only if its result has a slot waiting
    assign room      = (r_count + OUT_CNT_W'(r_rd_vld)) < OUT_CNT_W'(OUT_DEPTH);
    assign issue     = !i_cmd_empty && (i_cmd.is_write || room);
    assign o_cmd_pop = issue;

    always_ff @(posedge i_clk) begin
        if (issue && i_cmd.is_write) begin
            r_mem[addr] <= i_cmd.pixel;
        end
        r_rd_data   <= r_mem[addr];
        r_rd_status <= i_cmd.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue && !i_cmd.is_write;
        end
    end

    assign out_push = r_rd_vld;
    assign out_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (out_push && !out_pop) begin
            n_count = r_count + OUT_CNT_W'(1);
        end else if (out_pop && !out_push) begin
            n_count = r_count - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (out_push) begin
                r_wptr <= r_wptr + OUT_PTR_W'(1);
            end
            if (out_pop) begin
                r_rptr <= r_rptr + OUT_PTR_W'(1);
            end
        end
    end

    // error results carry a zero word
    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_out_pix[r_wptr]  <= (r_rd_status == ST_OK) ? r_rd_data : '0;
            r_out_stat[r_wptr] <= r_rd_status;
        end
    end

    assign o_empty     = (r_count == '0);
    assign o_pixel_out = r_out_pix[r_rptr];
    assign o_status    = r_out_stat[r_rptr];

    assign o_stat.rd_pending = r_rd_vld;
    assign o_stat.out_count  = r_count;

endmodule

@@ rtl/symmetric_border_padding.sv @@
// top level: frame store with half-sample symmetric mirrored border reads
// a read passes the front register, the command queue, the registered store read and the result queue
// throughput: one request per cycle while full is low, writes and reads mixed in any order
// the rate is set by the single-port frame store, one access per cycle
// reset clears the queues and sets width 512, height 512, border 0
// frame store contents are undefined after reset, no clearing pass is run
module symmetric_border_padding #(
    parameter int MAX_WIDTH  = sbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sbp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_BORDER = sbp_pkg::DEF_MAX_BORDER
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request side
    input  logic                            push,
    output logic                            full,
    input  logic                            i_opcode,
    input  logic [sbp_pkg::COORD_W-1:0]     i_row,
    input  logic [sbp_pkg::COORD_W-1:0]     i_column,
    input  logic [sbp_pkg::PIX_W-1:0]       i_pixel_in,
    // result side
    output logic                            empty,
    input  logic                            pop,
    output logic [sbp_pkg::PIX_W-1:0]       o_pixel_out,
    output logic [sbp_pkg::STAT_W-1:0]      o_status
);
    import sbp_pkg::*;

    localparam int CHK_W = OUT_CNT_W + 1;

    t_cfg        r_cfg;
    logic        cfg_we;
    logic        front_vld;
    t_cmd        front_cmd;
    t_cmd        q_cmd;
    t_queue_stat q_stat;
    logic        q_pop;
    t_back_stat  b_stat;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_IMAGE_WIDTH;
            r_cfg.height <= RST_IMAGE_HEIGHT;
            r_cfg.border <= RST_BORDER_SIZE;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg.width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg.height <= i_cfg_data[DIM_W-1:0];
                CFG_BORDER_SIZE:  r_cfg.border <= i_cfg_data[BORD_W-1:0];
                default: begin
                    // unused index, write is dropped
                end
            endcase
        end
    end

    // front: register stage that mirrors coordinates and sets the status
    sbp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_BORDER (MAX_BORDER)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .o_full     (full),
        .i_opcode   (i_opcode),
        .i_row      (i_row),
        .i_column   (i_column),
        .i_pixel_in (i_pixel_in),
        .o_cmd_vld  (front_vld),
        .o_cmd      (front_cmd),
        .i_q_full   (q_stat.full)
    );

    // decoupling queue, lets either half stall on its own
    sbp_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    // back: store write or registered read, then the result queue
    sbp_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_stat.empty),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_pixel_out (o_pixel_out),
        .o_status    (o_status),
        .o_stat      (b_stat)
    );

    // a read in flight always has a slot in the result queue
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CHK_W'(b_stat.out_count) + CHK_W'(b_stat.rd_pending)) <= CHK_W'(OUT_DEPTH))
        else $error("result queue overcommitted");

    // error results never carry pixel data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status != ST_OK)) |-> (o_pixel_out == '0))
        else $error("error result with nonzero pixel");

    // backpressure to the requester only comes from a full command queue
    a_full_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (q_stat.full && front_vld))
        else $error("full without a full command queue");

    // a request held in front moves on once the queue has space
    a_front_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_vld && !q_stat.full && !push) |=> !front_vld)
        else $error("front stage did not hand off");

endmodule
